>>> sv/upq_pkg.sv
// Shared types and constants for the unsorted array priority queue.
// No dependencies; compiled first.
package upq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int VAL_W = 16;
  localparam int PRI_W = 8;
  localparam int OCC_W = 4;

  typedef enum logic [0:0] {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // latch the accepted request
    logic search;  // register the max-priority position
    logic commit;  // update storage and load the result register
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;  // result register empty or being drained
  } dp_stat_t;

endpackage

>>> sv/upq_if.sv
// Request and result channel interfaces for the priority queue.
// Depends on upq_pkg.
interface upq_in_if import upq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [VAL_W-1:0] item_value;
  logic [PRI_W-1:0] item_priority;

  modport source (output valid, command, item_value, item_priority, input ready);
  modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

interface upq_out_if import upq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [VAL_W-1:0] out_value;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, status, out_value, occupancy, input ready);
  modport sink   (input valid, status, out_value, occupancy, output ready);
endinterface

>>> sv/upq_ctrl.sv
// Controller state machine: sequences accept, search and commit.
// Depends on upq_pkg.
module upq_ctrl import upq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // Commit and take the next request in the same cycle.
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          req_ready  = 1'b1;
          if (req_valid) begin
            cmd.load   = 1'b1;
            state_next = S_SEARCH;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> sv/upq_dp.sv
// Datapath: entry storage, max-priority search, gap close, result register.
// Depends on upq_pkg.
module upq_dp import upq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             req_command,
  input  logic [VAL_W-1:0] req_value,
  input  logic [PRI_W-1:0] req_priority,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [VAL_W-1:0] out_value,
  output logic [OCC_W-1:0] out_occupancy
);

  logic [VAL_W-1:0] vals [DEPTH];
  logic [PRI_W-1:0] pris [DEPTH];
  logic [CNT_W-1:0] count;

  logic             cmd_r;
  logic [VAL_W-1:0] val_r;
  logic [PRI_W-1:0] pri_r;
  logic [IDX_W-1:0] pos;
  logic [VAL_W-1:0] best_val;

  logic [IDX_W-1:0] srch_pos;
  logic [PRI_W-1:0] srch_pri;
  logic [VAL_W-1:0] srch_val;

  logic [CNT_W-1:0] count_next;
  status_t          status_next;
  logic [VAL_W-1:0] value_next;
  logic             do_enq;
  logic             do_deq;

  assign stat.out_free = !out_valid || out_ready;

  // Linear scan over valid entries; strict compare keeps earliest on ties.
  always_comb begin
    srch_pos = '0;
    srch_pri = pris[0];
    srch_val = vals[0];
    for (int i = 1; i < DEPTH; i++) begin
      if ((CNT_W'(i) < count) && (pris[i] > srch_pri)) begin
        srch_pos = IDX_W'(i);
        srch_pri = pris[i];
        srch_val = vals[i];
      end
    end
  end

  always_comb begin
    do_enq      = 1'b0;
    do_deq      = 1'b0;
    count_next  = count;
    status_next = ST_OK;
    value_next  = '0;
    if (cmd_r == CMD_ENQ) begin
      if (count == CNT_W'(DEPTH)) begin
        status_next = ST_OVERFLOW;
      end else begin
        do_enq     = 1'b1;
        count_next = count + 1'b1;
      end
    end else begin
      if (count == '0) begin
        status_next = ST_UNDERFLOW;
      end else begin
        do_deq     = 1'b1;
        count_next = count - 1'b1;
        value_next = best_val;
      end
    end
  end

  // Request latch and search result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= req_command;
      val_r <= req_value;
      pri_r <= req_priority;
    end
    if (cmd.search) begin
      pos      <= srch_pos;
      best_val <= srch_val;
    end
  end

  // Entry storage: append at tail or shift down above the removed slot.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (do_enq) begin
        vals[count[IDX_W-1:0]] <= val_r;
        pris[count[IDX_W-1:0]] <= pri_r;
      end else if (do_deq) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (IDX_W'(i) >= pos) begin
            vals[i] <= vals[i+1];
            pris[i] <= pris[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status    <= status_next;
      out_value     <= value_next;
      out_occupancy <= OCC_W'(count_next);
    end
  end

endmodule

>>> sv/unsorted_array_priority_queue.sv
// Top level of the unsorted array priority queue.
// Depends on upq_pkg, upq_if, upq_ctrl and upq_dp.
//
// A small priority queue of DEPTH (value, priority) pairs kept in arrival
// order. Each request carries a command: enqueue appends the pair at the
// tail (status overflow if full), dequeue returns the value with the highest
// priority, earliest arrival first on ties, then closes the gap (status
// underflow if empty). Every request yields exactly one result with the
// status, the removed value (zero unless a dequeue succeeded) and the
// occupancy after the command. Once a request is accepted, the search state
// registers the position found by the combinational priority scan of the
// entry registers; the finish state updates storage and loads the result
// register, and takes the next request as the last one commits while the
// result side keeps draining. The result register holds one finished
// result; while it is occupied and not taken, the commit waits.
module unsorted_array_priority_queue import upq_pkg::*; (
  input logic clk,
  input logic rst,
  upq_in_if.sink    req,
  upq_out_if.source rsp
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencing: accept, scan, commit.
  upq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // Storage, scan and result register.
  upq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .req_command   (req.command),
    .req_value     (req.item_value),
    .req_priority  (req.item_priority),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_status    (rsp.status),
    .out_value     (rsp.out_value),
    .out_occupancy (rsp.occupancy)
  );

endmodule

>>> dv/unsorted_array_priority_queue_test.sv
// Self-checking testbench for the unsorted array priority queue.
// Depends on upq_pkg, upq_if (upq_in_if, upq_out_if) and unsorted_array_priority_queue.
module unsorted_array_priority_queue_test import upq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD       = 20;
  localparam int RESET_CYCLES     = 2;
  // Slowest legal run is roughly 2000 requests plus the long hold-off; the
  // limit leaves about ten times its length.
  localparam int CYCLE_LIMIT      = 200000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int RANDOM_PER_PHASE = 485;
  localparam int HOLD_OFF_CYCLES  = 200;

  // One result as the queue should report it.
  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic [OCC_W-1:0] occupancy;
  } pq_result_t;

  logic clk = 1'b0;
  logic rst;

  upq_in_if  req_if ();
  upq_out_if rsp_if ();

  unsorted_array_priority_queue u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow copy of the queue contents, kept in arrival order.
  logic [VAL_W-1:0] shadow_values     [DEPTH];
  logic [PRI_W-1:0] shadow_priorities [DEPTH];
  int               shadow_count;

  pq_result_t  pending_results[$];  // results owed by the block, oldest first
  int          error_count;
  int unsigned cycle_count;

  // Idle controls, changed per phase by the test tasks.
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_request;  // picked up by the result-side process

  // Applies one accepted request to the shadow queue and returns the
  // result the block has to produce for it.
  function automatic pq_result_t serve_request(cmd_t cmd, logic [VAL_W-1:0] value,
                                               logic [PRI_W-1:0] prio);
    pq_result_t       res;
    int               pos;
    logic [PRI_W-1:0] best;
    res.status = ST_OK;
    res.value  = '0;
    if (cmd == CMD_ENQ) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        shadow_values[shadow_count]     = value;
        shadow_priorities[shadow_count] = prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_UNDERFLOW;
    end else begin
      // strict compare: earliest arrival wins a tie
      pos  = 0;
      best = shadow_priorities[0];
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_priorities[i] > best) begin
          best = shadow_priorities[i];
          pos  = i;
        end
      end
      res.value = shadow_values[pos];
      for (int i = pos; i + 1 < shadow_count; i++) begin
        shadow_values[i]     = shadow_values[i + 1];
        shadow_priorities[i] = shadow_priorities[i + 1];
      end
      shadow_count--;
    end
    res.occupancy = shadow_count[OCC_W-1:0];
    return res;
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high so a following request goes out back to back; valid drops only
  // in the random idle gaps before a request and in wait_for_idle.
  task automatic send_request(cmd_t cmd, logic [VAL_W-1:0] value, logic [PRI_W-1:0] prio);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.command       <= cmd;
    req_if.item_value    <= value;
    req_if.item_priority <= prio;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_results.push_back(serve_request(cmd, value, prio));
  endtask

  // Drops valid and waits until every owed result has been taken.
  task automatic wait_for_idle();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_random_request(int enq_pct);
    logic [PRI_W-1:0] prio;
    cmd_t             cmd;
    // bias toward a handful of priorities so ties are common
    case ($urandom_range(0, 3))
      0:       prio = PRI_W'($urandom_range(0, 3));
      1:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: prio = PRI_W'($urandom_range(0, 255));
    endcase
    cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
    send_request(cmd, VAL_W'($urandom), prio);
  endtask

  // Underflow on empty, field extremes, fill to overflow, drain to underflow.
  task automatic test_limits_and_extremes();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_request(CMD_DEQ, 16'h7FFF, 8'hFF);  // empty: underflow
    send_request(CMD_ENQ, 16'h8000, 8'h00);
    send_request(CMD_ENQ, 16'h7FFF, 8'hFF);
    send_request(CMD_ENQ, 16'h0000, 8'h80);
    send_request(CMD_ENQ, 16'hFFFF, 8'hFF);  // ties the earlier 255
    send_request(CMD_ENQ, 16'h0001, 8'h00);
    send_request(CMD_ENQ, 16'h5555, 8'hFF);
    send_request(CMD_ENQ, 16'hAAAA, 8'h01);
    send_request(CMD_ENQ, 16'hFFFE, 8'h7F);  // queue now full
    send_request(CMD_ENQ, 16'h1234, 8'hFF);  // full: overflow, nothing stored
    repeat (DEPTH) send_request(CMD_DEQ, 16'h0000, 8'h00);
    send_request(CMD_DEQ, 16'hFFFF, 8'hFF);  // empty again: underflow
    wait_for_idle();
  endtask

  // Equal priorities must come out in arrival order, also after a removal
  // from the middle.
  task automatic test_tie_break();
    send_request(CMD_ENQ, 16'd10, 8'd7);
    send_request(CMD_ENQ, 16'd20, 8'd9);
    send_request(CMD_ENQ, 16'd30, 8'd7);
    send_request(CMD_DEQ, 16'd0, 8'd0);  // 20
    send_request(CMD_DEQ, 16'd0, 8'd0);  // 10 before 30
    send_request(CMD_DEQ, 16'd0, 8'd0);
    wait_for_idle();
  endtask

  // Result side holds off while requests keep coming: the queue fills,
  // overflows, the result register stays occupied and the input stalls.
  task automatic test_backpressure_fill();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_request   = HOLD_OFF_CYCLES;
    for (int i = 0; i < 12; i++) send_random_request(100);
    for (int i = 0; i < 12; i++) send_random_request(0);
    wait_for_idle();
  endtask

  // Random traffic in runs that lean toward filling, balancing or draining
  // so that full and empty are both visited often.
  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    int enq_pct;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    enq_pct            = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 80;
          1:       enq_pct = 50;
          default: enq_pct = 20;
        endcase
      end
      send_random_request(enq_pct);
    end
    wait_for_idle();
  endtask

  // Result side: random stalls per phase, plus the long hold-off when asked.
  initial begin
    int hold_left;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Every taken result is matched against the oldest owed one.
  always @(posedge clk) begin
    pq_result_t exp;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result status=%0d value=%0d occupancy=%0d", $time,
                 rsp_if.status, $signed(rsp_if.out_value), rsp_if.occupancy);
      end else begin
        exp = pending_results.pop_front();
        if (rsp_if.status !== exp.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, exp.status, rsp_if.status);
        end
        if (rsp_if.out_value !== exp.value) begin
          error_count++;
          $display("%0t: out_value expected %0d actual %0d", $time, $signed(exp.value),
                   $signed(rsp_if.out_value));
        end
        if (rsp_if.occupancy !== exp.occupancy) begin
          error_count++;
          $display("%0t: occupancy expected %0d actual %0d", $time, exp.occupancy,
                   rsp_if.occupancy);
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    error_count          = 0;
    cycle_count          = 0;
    shadow_count         = 0;
    sender_idle_pct      = 0;
    receiver_stall_pct   = 0;
    hold_off_request     = 0;
    rst                  <= 1'b1;
    req_if.valid         <= 1'b0;
    req_if.command       <= CMD_ENQ;
    req_if.item_value    <= '0;
    req_if.item_priority <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_limits_and_extremes();
    test_tie_break();
    test_backpressure_fill();
    test_random_traffic(RANDOM_PER_PHASE, 0, 0);    // no idling
    test_random_traffic(RANDOM_PER_PHASE, 72, 0);   // sparse requests
    test_random_traffic(RANDOM_PER_PHASE, 0, 72);   // slow result side
    test_random_traffic(RANDOM_PER_PHASE, 23, 23);  // both sides idle

    // let any stray result show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
